// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the deletion syndrome block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge outside reset.
`define DSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define DSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
// Package: sizes, codes and shared types of the deletion syndrome block.
package dss_pkg;

  localparam int MAX_POSITIONS        = 32;
  localparam int MAX_CONSTRAINT_COUNT = 8;
  localparam int WEIGHT_BITS          = 48;

  localparam int POS_W   = $clog2(MAX_POSITIONS);
  localparam int CI_W    = $clog2(MAX_CONSTRAINT_COUNT);
  localparam int ADDR_W  = CI_W + POS_W;
  localparam int W_DEPTH = MAX_CONSTRAINT_COUNT * MAX_POSITIONS;

  // Field widths of the channels
  localparam int OP_W       = 2;
  localparam int WIN_W      = 48;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 6;
  localparam int NC_W       = 4;
  localparam int MOD_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Accumulator: 32 differences of two weights each
  localparam int ACC_W      = WEIGHT_BITS + POS_W + 1;
  localparam int STEP_W     = POS_W + 1;
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT  = 2'd0,
    OP_LOAD_MODULUS = 2'd1,
    OP_COMPUTE      = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LENGTH    = 2'd0,
    CFG_NUM_CONSTRAINTS = 2'd1
  } cfg_idx_e;

  // Request to the modulo unit
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [MOD_W-1:0] modulus;
  } div_req_t;

  // Answer of the modulo unit
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] residue;
  } div_rsp_t;

endpackage

// ===== rtl/dss_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface dss_in_if;
  logic                                valid;
  logic                                ready;
  logic [dss_pkg::OP_W-1:0]            operation;
  logic [dss_pkg::CI_W-1:0]            constraint_index;
  logic [dss_pkg::POS_W-1:0]           position;
  logic signed [dss_pkg::WIN_W-1:0]    weight_value;
  logic [dss_pkg::MOD_W-1:0]           modulus_value;
  logic [dss_pkg::WORD_W-1:0]          codeword;
  logic [dss_pkg::WORD_W-1:0]          deletion_mask;

  modport source (output valid, operation, constraint_index, position, weight_value,
                  modulus_value, codeword, deletion_mask, input ready);
  modport sink   (input valid, operation, constraint_index, position, weight_value,
                  modulus_value, codeword, deletion_mask, output ready);
endinterface

interface dss_out_if;
  logic                       valid;
  logic                       ready;
  logic [dss_pkg::WORD_W-1:0] rx_word;
  logic [dss_pkg::LEN_W-1:0]  received_length;
  logic [dss_pkg::MOD_W-1:0]  delta_0;
  logic [dss_pkg::MOD_W-1:0]  delta_1;
  logic [dss_pkg::MOD_W-1:0]  delta_2;
  logic [dss_pkg::MOD_W-1:0]  delta_3;
  logic [dss_pkg::MOD_W-1:0]  delta_4;
  logic [dss_pkg::MOD_W-1:0]  delta_5;
  logic [dss_pkg::MOD_W-1:0]  delta_6;
  logic [dss_pkg::MOD_W-1:0]  delta_7;

  modport source (output valid, rx_word, received_length, delta_0, delta_1, delta_2,
                  delta_3, delta_4, delta_5, delta_6, delta_7, input ready);
  modport sink   (input valid, rx_word, received_length, delta_0, delta_1, delta_2,
                  delta_3, delta_4, delta_5, delta_6, delta_7, output ready);
endinterface

interface dss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dss_pkg::CFG_IDX_W-1:0]  index;
  logic [dss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/deletion_syndrome_signature.sv =====
// Top level of the deletion syndrome signature block.
// A weight load writes the weight RAM, a modulus load one of eight modulus registers.
// A compute item compacts the received word one position a cycle, then for each of the
// r constraints sums weights over the n positions, where n is the saturated block length
// and r the saturated constraint count. The single read port of the weight RAM delivers
// one weight a cycle (two reads per position and constraint), and the shared bit-serial
// modulo unit reduces each sum in turn. The input channel is ready only while no compute
// item is at work; a finished result waits in an output register, so the next item may
// be accepted while it is still held.
`include "assert_macros.svh"

module deletion_syndrome_signature (
  input  logic       clk_i,
  input  logic       rst_ni,
  dss_in_if.sink     in_i,
  dss_out_if.source  out_o,
  dss_cfg_if.sink    cfg_i
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_WORD      = 8'b0000_0010,
    ST_CSTART    = 8'b0000_0100,
    ST_ACC       = 8'b0000_1000,
    ST_DRAIN     = 8'b0001_0000,
    ST_DIV_START = 8'b0010_0000,
    ST_DIV_WAIT  = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_e;

  localparam logic [dss_pkg::POS_W-1:0] TOP_BIT = dss_pkg::POS_W'(dss_pkg::WORD_W - 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [dss_pkg::LEN_W-1:0] block_length_q;
  logic [dss_pkg::NC_W-1:0]  num_constraints_q;
  logic [dss_pkg::LEN_W-1:0] n_sat;
  logic [dss_pkg::NC_W-1:0]  r_sat;

  // Working registers of one compute item
  logic [dss_pkg::LEN_W-1:0]   n_q, n_d;
  logic [dss_pkg::NC_W-1:0]    r_q, r_d;
  logic [dss_pkg::WORD_W-1:0]  cw_q, cw_d;
  logic [dss_pkg::WORD_W-1:0]  dm_q, dm_d;
  logic [dss_pkg::WORD_W-1:0]  word_q, word_d;
  logic [dss_pkg::LEN_W-1:0]   kept_q, kept_d;
  logic [dss_pkg::POS_W-1:0]   i_q, i_d;
  logic [dss_pkg::NC_W-1:0]    j_q, j_d;
  logic [dss_pkg::STEP_W-1:0]  k_q, k_d;
  logic [dss_pkg::LEN_W-1:0]   s_q, s_d;
  logic signed [dss_pkg::ACC_W-1:0] acc_q, acc_d;
  logic                        pend_add_q, pend_add_d;
  logic                        pend_sub_q, pend_sub_d;
  logic [dss_pkg::MOD_W-1:0]   delta_q [dss_pkg::MAX_CONSTRAINT_COUNT];
  logic [dss_pkg::MOD_W-1:0]   delta_d [dss_pkg::MAX_CONSTRAINT_COUNT];
  logic [dss_pkg::MOD_W-1:0]   mod_q   [dss_pkg::MAX_CONSTRAINT_COUNT];

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;
  logic [dss_pkg::WORD_W-1:0]  out_word_q;
  logic [dss_pkg::LEN_W-1:0]   out_len_q;
  logic [dss_pkg::MOD_W-1:0]   out_delta_q [dss_pkg::MAX_CONSTRAINT_COUNT];

  logic                        in_xfer;
  logic [dss_pkg::LEN_W:0]     shamt;

  // Weight RAM ports
  logic                            ram_we;
  logic [dss_pkg::ADDR_W-1:0]      ram_waddr;
  logic [dss_pkg::ADDR_W-1:0]      ram_raddr;
  logic [dss_pkg::WEIGHT_BITS-1:0] ram_rdata;

  // Sequencer decode of the current step
  logic [dss_pkg::POS_W-1:0]   pos;
  logic                        half;
  logic                        bit_c;
  logic                        del_c;
  logic [dss_pkg::POS_W-1:0]   sub_pos;
  logic [dss_pkg::STEP_W-1:0]  k_last;
  logic [dss_pkg::LEN_W:0]     two_n;
  logic [dss_pkg::LEN_W-1:0]   sub_diff;

  logic signed [dss_pkg::ACC_W-1:0] w_ext;
  logic signed [dss_pkg::ACC_W-1:0] addend;

  dss_pkg::div_req_t div_req;
  dss_pkg::div_rsp_t div_rsp;

  // Configuration port: always ready, unknown indexes ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q    <= dss_pkg::LEN_W'(dss_pkg::MAX_POSITIONS);
      num_constraints_q <= dss_pkg::NC_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dss_pkg::CFG_BLOCK_LENGTH:    block_length_q    <= cfg_i.data[dss_pkg::LEN_W-1:0];
        dss_pkg::CFG_NUM_CONSTRAINTS: num_constraints_q <= cfg_i.data[dss_pkg::NC_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_sat = (block_length_q > dss_pkg::LEN_W'(dss_pkg::MAX_POSITIONS))
               ? dss_pkg::LEN_W'(dss_pkg::MAX_POSITIONS) : block_length_q;
  assign r_sat = (num_constraints_q > dss_pkg::NC_W'(dss_pkg::MAX_CONSTRAINT_COUNT))
               ? dss_pkg::NC_W'(dss_pkg::MAX_CONSTRAINT_COUNT) : num_constraints_q;

  // Input channel
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Left-align codeword and mask so position i sits in bit WORD_W-1-i
  assign shamt = (dss_pkg::LEN_W + 1)'(dss_pkg::WORD_W) - {1'b0, n_sat};

  // Weight RAM: written by weight loads, read by the accumulation steps
  assign ram_we    = in_xfer && (in_i.operation == dss_pkg::OP_LOAD_WEIGHT);
  assign ram_waddr = {in_i.constraint_index, in_i.position};

  dss_ram #(
    .WIDTH (dss_pkg::WEIGHT_BITS),
    .DEPTH (dss_pkg::W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.weight_value[dss_pkg::WEIGHT_BITS-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Modulus registers, read at the constraint counter only
  always_ff @(posedge clk_i) begin
    if (in_xfer && (in_i.operation == dss_pkg::OP_LOAD_MODULUS)) begin
      mod_q[in_i.constraint_index] <= in_i.modulus_value;
    end
  end

  // Step decode: even steps read w[i], odd steps read w[i-shift]
  assign pos      = k_q[dss_pkg::STEP_W-1:1];
  assign half     = k_q[0];
  assign bit_c    = cw_q[TOP_BIT - pos];
  assign del_c    = dm_q[TOP_BIT - pos];
  assign sub_diff = dss_pkg::LEN_W'(pos) - s_q;
  assign sub_pos  = sub_diff[dss_pkg::POS_W-1:0];
  assign two_n    = {n_q, 1'b0} - (dss_pkg::LEN_W + 1)'(1);
  assign k_last   = two_n[dss_pkg::STEP_W-1:0];
  assign ram_raddr = {j_q[dss_pkg::CI_W-1:0], half ? sub_pos : pos};

  // Accumulate the weight in the cycle after its read
  assign w_ext  = {{(dss_pkg::ACC_W - dss_pkg::WEIGHT_BITS){ram_rdata[dss_pkg::WEIGHT_BITS-1]}},
                   ram_rdata};
  assign addend = pend_add_q ? w_ext : (pend_sub_q ? -w_ext : '0);

  // Modulo unit request
  assign div_req.start   = (state_q == ST_DIV_START);
  assign div_req.neg     = acc_q[dss_pkg::ACC_W-1];
  assign div_req.mag     = acc_q[dss_pkg::ACC_W-1] ? dss_pkg::ACC_W'(-acc_q)
                                                   : dss_pkg::ACC_W'(acc_q);
  assign div_req.modulus = mod_q[j_q[dss_pkg::CI_W-1:0]];

  dss_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    r_d        = r_q;
    cw_d       = cw_q;
    dm_d       = dm_q;
    word_d     = word_q;
    kept_d     = kept_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    s_d        = s_q;
    delta_d    = delta_q;
    pend_add_d = 1'b0;
    pend_sub_d = 1'b0;
    acc_d      = acc_q + addend;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.operation == dss_pkg::OP_COMPUTE)) begin
          n_d     = n_sat;
          r_d     = r_sat;
          cw_d    = in_i.codeword << shamt;
          dm_d    = in_i.deletion_mask << shamt;
          word_d  = '0;
          kept_d  = '0;
          i_d     = '0;
          j_d     = '0;
          for (int c = 0; c < dss_pkg::MAX_CONSTRAINT_COUNT; c++) begin
            delta_d[c] = '0;
          end
          state_d = (n_sat == '0) ? ST_CSTART : ST_WORD;
        end
      end
      ST_WORD: begin
        // Compact kept bits, one position a cycle
        if (!dm_q[TOP_BIT - i_q]) begin
          word_d = {word_q[dss_pkg::WORD_W-2:0], cw_q[TOP_BIT - i_q]};
          kept_d = kept_q + 1'b1;
        end
        if (dss_pkg::LEN_W'(i_q) == n_q - 1'b1) begin
          state_d = ST_CSTART;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_CSTART: begin
        if (j_q >= r_q) begin
          state_d = ST_DONE;
        end else begin
          acc_d   = '0;
          k_d     = '0;
          s_d     = '0;
          state_d = (n_q == '0) ? ST_DRAIN : ST_ACC;
        end
      end
      ST_ACC: begin
        pend_add_d = !half && bit_c;
        pend_sub_d = half && bit_c && !del_c;
        if (half && del_c) begin
          s_d = s_q + 1'b1;
        end
        if (k_q == k_last) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          delta_d[j_q[dss_pkg::CI_W-1:0]] = div_rsp.residue;
          j_d     = j_q + 1'b1;
          state_d = ST_CSTART;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_add_q  <= 1'b0;
      pend_sub_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_add_q  <= pend_add_d;
      pend_sub_q  <= pend_sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    r_q     <= r_d;
    cw_q    <= cw_d;
    dm_q    <= dm_d;
    word_q  <= word_d;
    kept_q  <= kept_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    s_q     <= s_d;
    acc_q   <= acc_d;
    delta_q <= delta_d;
    if (out_load) begin
      out_word_q  <= word_q;
      out_len_q   <= kept_q;
      out_delta_q <= delta_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.rx_word         = out_word_q;
  assign out_o.received_length = out_len_q;
  assign out_o.delta_0         = out_delta_q[0];
  assign out_o.delta_1         = out_delta_q[1];
  assign out_o.delta_2         = out_delta_q[2];
  assign out_o.delta_3         = out_delta_q[3];
  assign out_o.delta_4         = out_delta_q[4];
  assign out_o.delta_5         = out_delta_q[5];
  assign out_o.delta_6         = out_delta_q[6];
  assign out_o.delta_7         = out_delta_q[7];

  `DSS_ASSERT(a_shift_le_pos,
              ((state_q == ST_ACC) && half) |-> (s_q <= dss_pkg::LEN_W'(pos)),
              "deletion count exceeds position")
  `DSS_ASSERT(a_kept_le_n,
              (state_q == ST_CSTART) |-> (kept_q <= n_q),
              "kept count exceeds block length")
  `DSS_ASSERT(a_out_from_done,
              $rose(out_valid_q) |-> $past(state_q == ST_DONE),
              "result raised outside done state")
  `DSS_ASSERT(a_div_done_wait,
              div_rsp.done |-> (state_q == ST_DIV_WAIT),
              "modulo result while not waiting")

endmodule

// ===== rtl/dss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/dss_divider.sv =====
// Bit-serial modulo unit: signed sum modulo a 31-bit modulus, one dividend bit a cycle.
`include "assert_macros.svh"

module dss_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dss_pkg::div_req_t req_i,
  output dss_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [dss_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [dss_pkg::MOD_W-1:0]         rem_q, rem_d;
  logic [dss_pkg::ACC_W-1:0]         dvd_q, dvd_d;
  logic [dss_pkg::MOD_W-1:0]         m_q, m_d;
  logic                              neg_q, neg_d;
  logic [dss_pkg::MOD_W-1:0]         res_q, res_d;

  logic [dss_pkg::MOD_W:0]           rem_sh;
  logic [dss_pkg::MOD_W:0]           rem_sub;
  logic [dss_pkg::MOD_W-1:0]         rem_nx;
  logic                              last;

  // Restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[dss_pkg::ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, m_q};
  assign rem_nx  = (rem_sh >= {1'b0, m_q}) ? rem_sub[dss_pkg::MOD_W-1:0]
                                           : rem_sh[dss_pkg::MOD_W-1:0];
  assign last    = (cnt_q == dss_pkg::DIV_CNT_W'(dss_pkg::ACC_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    m_d    = m_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.mag;
      m_d    = req_i.modulus;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      rem_d = rem_nx;
      dvd_d = {dvd_q[dss_pkg::ACC_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // Negative sums fold back into 0..m-1; a zero modulus gives zero
        if (m_q == '0) begin
          res_d = '0;
        end else if (neg_q && (rem_nx != '0)) begin
          res_d = m_q - rem_nx;
        end else begin
          res_d = rem_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    m_q   <= m_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.residue = res_q;

  `DSS_ASSERT_NEVER(a_start_while_busy, req_i.start && busy_q, "start while modulo unit busy")
  `DSS_ASSERT(a_rem_bounded, (busy_q && (m_q != '0)) |-> (rem_q < m_q), "partial remainder >= m")
  `DSS_ASSERT(a_res_bounded, (done_q && (m_q != '0)) |-> (res_q < m_q), "residue >= modulus")

endmodule
